// File: rtl/mtke_pkg.sv
// Shared types and constants for the multi-tap keypad entry block.
// Used by mtke_decode, mtke_tap and multitap_keypad_entry; no dependencies.
package mtke_pkg;

   localparam int KEY_W    = 6;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;

   localparam logic [CHAR_W-1:0] TIMEOUT_RESET = 8'd10;

   localparam logic [KEY_W-1:0] FIRST_DIRECT_KEY = 6'd13;

   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FIRST     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CYCLED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COMMITTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DIRECT    = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHAR_W-1:0]   out_char;
      logic                char_written;
   } result_type;

endpackage

// File: rtl/mtke_decode.sv
// Key decoder: turns the four column readings into a key code.
// Depends on mtke_pkg.
module mtke_decode (
   input  logic [3:0]              scan_col0,
   input  logic [3:0]              scan_col1,
   input  logic [3:0]              scan_col2,
   input  logic [3:0]              scan_col3,
   output logic [mtke_pkg::KEY_W-1:0] key
);
   import mtke_pkg::*;

   localparam logic [KEY_W-1:0] MAP_NORMAL [17] = '{
      6'd0, 6'd1, 6'd2, 6'd3, 6'd13, 6'd4, 6'd5, 6'd6, 6'd14,
      6'd7, 6'd8, 6'd9, 6'd15, 6'd10, 6'd11, 6'd12, 6'd16};
   localparam logic [KEY_W-1:0] MAP_SHIFT [17] = '{
      6'd0, 6'd21, 6'd22, 6'd23, 6'd33, 6'd24, 6'd25, 6'd26, 6'd34,
      6'd27, 6'd28, 6'd29, 6'd35, 6'd30, 6'd31, 6'd32, 6'd36};

   logic [3:0] cols [4];
   logic [3:0] col_bits;
   logic [4:0] key_idx;
   logic       shift;

   assign cols[0] = scan_col0;
   assign cols[1] = scan_col1;
   assign cols[2] = scan_col2;
   assign cols[3] = scan_col3;

   // A column counts only with exactly one row pressed; later columns win.
   always_comb begin
      key_idx  = '0;
      shift    = 1'b0;
      col_bits = '0;
      for (int i = 0; i < 4; i++) begin
         col_bits = cols[i];
         if (i == 3 && col_bits[0]) begin
            shift    = 1'b1;
            col_bits = col_bits & 4'hE;
         end
         if (col_bits == 4'h1) key_idx = 5'(i * 4 + 4);
         if (col_bits == 4'h2) key_idx = 5'(i * 4 + 3);
         if (col_bits == 4'h4) key_idx = 5'(i * 4 + 2);
         if (col_bits == 4'h8) key_idx = 5'(i * 4 + 1);
      end
   end

   assign key = shift ? MAP_SHIFT[key_idx] : MAP_NORMAL[key_idx];

endmodule

// File: rtl/mtke_tap.sv
// Multi-tap state machine: holds the tap state and forms one result per item.
// Depends on mtke_pkg.
module mtke_tap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          text_mode,
   input  logic [mtke_pkg::KEY_W-1:0]    key,
   input  logic [mtke_pkg::CHAR_W-1:0]   tap_timeout,
   output mtke_pkg::result_type          result
);
   import mtke_pkg::*;

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_START   = 4'd1;
   localparam logic [3:0] PH_TENT    = 4'd2;
   localparam logic [3:0] PH_COMMIT  = 4'd3;
   localparam logic [3:0] PH_CYCLE   = 4'd4;
   localparam logic [3:0] PH_RESTART = 4'd10;

   localparam logic [7:0] ROW_CHARS [16][8] = '{
      '{8'h2A, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h62, 8'h63, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h65, 8'h66, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h68, 8'h69, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6A, 8'h6B, 8'h6C, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6D, 8'h6E, 8'h6F, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h71, 8'h72, 8'h73, 8'h37, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h75, 8'h76, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h78, 8'h79, 8'h7A, 8'h39, 8'h00, 8'h00, 8'h00},
      '{8'h23, 8'h24, 8'h40, 8'h2A, 8'h3F, 8'h00, 8'h00, 8'h00},
      '{8'h30, 8'h2E, 8'h2C, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h28, 8'h29, 8'h5F, 8'h26, 8'h25, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};
   localparam logic [2:0] ROW_LEN [16] = '{
      3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4,
      3'd5, 3'd5, 3'd4, 3'd5, 3'd1, 3'd1, 3'd1, 3'd1};

   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic [1:0]        tap_phase_ff, tap_phase_in;
   logic [CHAR_W-1:0] tap_timer_ff, tap_timer_in;
   logic [3:0]        pressed_key_ff, pressed_key_in;
   logic [3:0]        held_key_ff, held_key_in;
   logic [2:0]        letter_pos_ff, letter_pos_in;
   logic [CHAR_W-1:0] pending_char_ff, pending_char_in;

   logic [3:0]          phase;
   logic [3:0]          row;
   logic [2:0]          next_pos;
   logic                press_edge;
   logic [STATUS_W-1:0] status;

   assign press_edge = (key != '0) && (prev_key_ff == '0);

   always_comb begin
      prev_key_in     = prev_key_ff;
      tap_phase_in    = tap_phase_ff;
      tap_timer_in    = tap_timer_ff;
      pressed_key_in  = pressed_key_ff;
      held_key_in     = held_key_ff;
      letter_pos_in   = letter_pos_ff;
      pending_char_in = pending_char_ff;
      phase           = {2'b00, tap_phase_ff};
      row             = '0;
      next_pos        = '0;
      status          = ST_NONE;
      result          = '0;
      if (text_mode) begin
         prev_key_in = key;
         if (key >= FIRST_DIRECT_KEY) begin
            if (press_edge) begin
               result.status       = ST_DIRECT;
               result.out_char     = CHAR_W'(key);
               result.char_written = 1'b1;
            end
         end else begin
            if (press_edge) begin
               pressed_key_in = key[3:0];
               if (phase == PH_IDLE) begin
                  phase = PH_START;
               end else if (key[3:0] != held_key_ff) begin
                  phase = PH_RESTART;
               end else begin
                  phase = PH_CYCLE;
               end
            end
            row = pressed_key_in - 4'd1;
            if (phase == PH_START) begin
               tap_timer_in    = tap_timeout;
               phase           = PH_TENT;
               letter_pos_in   = '0;
               pending_char_in = ROW_CHARS[row][0];
               held_key_in     = pressed_key_in;
               status          = ST_FIRST;
            end
            if (phase == PH_TENT) begin
               if (tap_timer_in != '0) begin
                  tap_timer_in = tap_timer_in - 8'd1;
               end else begin
                  phase = PH_COMMIT;
               end
            end
            if (phase == PH_COMMIT) begin
               phase  = PH_IDLE;
               status = ST_COMMITTED;
            end
            if (phase == PH_CYCLE) begin
               tap_timer_in = tap_timeout;
               phase        = PH_TENT;
               next_pos     = letter_pos_ff + 3'd1;
               if (next_pos >= ROW_LEN[row]) begin
                  next_pos = '0;
               end
               letter_pos_in   = next_pos;
               pending_char_in = ROW_CHARS[row][next_pos];
               status          = ST_CYCLED;
            end
            if (phase == PH_RESTART) begin
               phase  = PH_START;
               status = ST_COMMITTED;
            end
            tap_phase_in        = phase[1:0];
            result.status       = status;
            result.out_char     = pending_char_in;
            result.char_written = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff     <= '0;
         tap_phase_ff    <= '0;
         tap_timer_ff    <= '0;
         pressed_key_ff  <= '0;
         held_key_ff     <= '0;
         letter_pos_ff   <= '0;
         pending_char_ff <= '0;
      end else if (step) begin
         prev_key_ff     <= prev_key_in;
         tap_phase_ff    <= tap_phase_in;
         tap_timer_ff    <= tap_timer_in;
         pressed_key_ff  <= pressed_key_in;
         held_key_ff     <= held_key_in;
         letter_pos_ff   <= letter_pos_in;
         pending_char_ff <= pending_char_in;
      end
   end

   a_first_leaves_tentative: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_FIRST |=> tap_phase_ff == PH_TENT[1:0])
      else $error("first tentative item did not leave the machine tentative");

   a_phase_never_commit: assert property (@(posedge clock) disable iff (reset)
      tap_phase_ff != PH_COMMIT[1:0])
      else $error("commit phase was stored");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(tap_phase_ff) && $stable(prev_key_ff) && $stable(pending_char_ff))
      else $error("tap state changed without an item");

   a_text_off_holds: assert property (@(posedge clock) disable iff (reset)
      step && !text_mode |=> $stable(tap_phase_ff) && $stable(prev_key_ff))
      else $error("tap state changed while text mode was off");

   a_pos_in_row: assert property (@(posedge clock) disable iff (reset)
      letter_pos_ff < 3'd5)
      else $error("letter position beyond the longest row");

endmodule

// File: rtl/multitap_keypad_entry.sv
// Multi-tap keypad text entry block: input register, decode and tap logic,
// result register. The only loop is the tap state update.
// Throughput is one item per cycle while the output is not stalled.
// Synchronous active-high reset empties both registers, clears the tap state
// and sets the tap timeout to 10 poll ticks. Depends on mtke_pkg, mtke_decode, mtke_tap.
module multitap_keypad_entry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_scan_col0,
   input  logic [3:0]                        req_scan_col1,
   input  logic [3:0]                        req_scan_col2,
   input  logic [3:0]                        req_scan_col3,
   input  logic                              req_text_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mtke_pkg::STATUS_W-1:0]     rsp_status,
   output logic [mtke_pkg::CHAR_W-1:0]       rsp_out_char,
   output logic                              rsp_char_written,
   input  logic                              csr_wr_en,
   input  logic [mtke_pkg::CHAR_W-1:0]       csr_wr_data
);
   import mtke_pkg::*;

   logic              in_valid_ff;
   logic [3:0]        col0_ff, col1_ff, col2_ff, col3_ff;
   logic              text_mode_ff;
   logic [CHAR_W-1:0] tap_timeout_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   result_type        result;
   logic [KEY_W-1:0]  key;
   logic              advance;
   logic              accept;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col0_ff      <= req_scan_col0;
         col1_ff      <= req_scan_col1;
         col2_ff      <= req_scan_col2;
         col3_ff      <= req_scan_col3;
         text_mode_ff <= req_text_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         tap_timeout_ff <= csr_wr_data;
      end
   end

   mtke_decode u_decode (
      .scan_col0 (col0_ff),
      .scan_col1 (col1_ff),
      .scan_col2 (col2_ff),
      .scan_col3 (col3_ff),
      .key       (key)
   );

   mtke_tap u_tap (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_mode   (text_mode_ff),
      .key         (key),
      .tap_timeout (tap_timeout_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_char     = rsp_ff.out_char;
   assign rsp_char_written = rsp_ff.char_written;

endmodule

// File: sim/multitap_keypad_entry_test.sv
// Self-checking testbench for multitap_keypad_entry: scans keypad ticks through the
// block under random idling and back-pressure and checks every result against a
// cycle-free model of the decode and multi-tap logic. Depends on mtke_pkg and the RTL.
`timescale 1ns / 100ps

module multitap_keypad_entry_test;
   import mtke_pkg::*;

   typedef struct packed {
      logic [3:0][3:0] cols;
      logic            text_mode;
   } scan_item_type;

   typedef enum int {
      PH_IDLE   = 0,
      PH_START  = 1,
      PH_SHOWN  = 2,
      PH_COMMIT = 3,
      PH_CYCLE  = 4,
      PH_SWITCH = 10
   } tap_phase_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [3:0]          req_scan_col0 = '0;
   logic [3:0]          req_scan_col1 = '0;
   logic [3:0]          req_scan_col2 = '0;
   logic [3:0]          req_scan_col3 = '0;
   logic                req_text_mode = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [CHAR_W-1:0]   rsp_out_char;
   logic                rsp_char_written;
   logic                csr_wr_en = 1'b0;
   logic [CHAR_W-1:0]   csr_wr_data = '0;

   scan_item_type pending_scans[$];
   result_type    awaited_results[$];
   int            queued_items = 0;
   int            results_seen = 0;
   int            error_count = 0;
   int            idle_pct = 7;
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   logic [5:0]        last_code = '0;
   tap_phase_type     tap_state = PH_IDLE;
   logic [7:0]        tap_count = '0;
   logic [3:0]        tapped_key = '0;
   logic [3:0]        owner_key = '0;
   logic [2:0]        letter_index = '0;
   logic [7:0]        shown_char = '0;
   logic [CHAR_W-1:0] timeout_ticks = TIMEOUT_RESET;

   multitap_keypad_entry dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_col0    (req_scan_col0),
      .req_scan_col1    (req_scan_col1),
      .req_scan_col2    (req_scan_col2),
      .req_scan_col3    (req_scan_col3),
      .req_text_mode    (req_text_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_written (rsp_char_written),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic string row_text(int row);
      case (row)
         0: return "*1";
         1: return "abc2";
         2: return "def3";
         3: return "ghi4";
         4: return "jkl5";
         5: return "mno6";
         6: return "pqrs7";
         7: return "tuv8";
         8: return "wxyz9";
         9: return "#$@*?";
         10: return "0.,!";
         11: return "()_&%";
         default: return "";
      endcase
   endfunction

   function automatic logic [5:0] key_code(logic [3:0][3:0] cols);
      logic [3:0] t;
      logic       shift;
      int         k;
      int         code;
      shift = 1'b0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
         t = cols[i];
         if (i == 3 && t[0]) begin
            shift = 1'b1;
            t[0] = 1'b0;
         end
         case (t)
            4'b0001: k = i * 4 + 4;
            4'b0010: k = i * 4 + 3;
            4'b0100: k = i * 4 + 2;
            4'b1000: k = i * 4 + 1;
            default: ;
         endcase
      end
      if (k == 0) begin
         code = 0;
      end else if (k % 4 == 0) begin
         code = 12 + k / 4;
      end else begin
         code = (k / 4) * 3 + k % 4;
      end
      if (shift && k != 0) begin
         code = code + 20;
      end
      return 6'(code);
   endfunction

   function automatic result_type entry_result(scan_item_type s);
      result_type          r;
      logic [5:0]          code;
      logic                pressed_now;
      tap_phase_type       ph;
      logic [STATUS_W-1:0] status;
      int                  row;
      int                  width;
      string               letters;
      r = '0;
      if (!s.text_mode) begin
         return r;
      end
      code = key_code(s.cols);
      pressed_now = (code != 0) && (last_code == 0);
      if (code >= FIRST_DIRECT_KEY) begin
         last_code = code;
         if (pressed_now) begin
            r.status = ST_DIRECT;
            r.out_char = {2'b00, code};
            r.char_written = 1'b1;
         end
         return r;
      end
      ph = tap_state;
      if (pressed_now) begin
         tapped_key = code[3:0];
         if (ph == PH_IDLE) begin
            ph = PH_START;
         end else begin
            ph = (tapped_key != owner_key) ? PH_SWITCH : PH_CYCLE;
         end
      end
      last_code = code;
      row = (int'(tapped_key) + 15) % 16;
      letters = row_text(row);
      width = (row < 12) ? letters.len() : 1;
      status = ST_NONE;
      if (ph == PH_START) begin
         tap_count = timeout_ticks;
         ph = PH_SHOWN;
         letter_index = '0;
         shown_char = (letters.len() > 0) ? letters.getc(0) : 8'd0;
         owner_key = tapped_key;
         status = ST_FIRST;
      end
      if (ph == PH_SHOWN) begin
         if (tap_count > 0) begin
            tap_count = tap_count - 8'd1;
         end else begin
            ph = PH_COMMIT;
         end
      end
      if (ph == PH_COMMIT) begin
         ph = PH_IDLE;
         status = ST_COMMITTED;
      end
      if (ph == PH_CYCLE) begin
         tap_count = timeout_ticks;
         ph = PH_SHOWN;
         letter_index = letter_index + 3'd1;
         if (letter_index >= width) begin
            letter_index = '0;
         end
         shown_char = (letter_index < letters.len()) ? letters.getc(letter_index) : 8'd0;
         status = ST_CYCLED;
      end
      if (ph == PH_SWITCH) begin
         ph = PH_START;
         status = ST_COMMITTED;
      end
      tap_state = ph;
      r.status = status;
      r.out_char = shown_char;
      r.char_written = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < 200) begin
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      error_count++;
   endtask

   function automatic logic [3:0] loose_bits(int width);
      logic [3:0] v;
      v = 4'($urandom_range((1 << width) - 1));
      while ($countones(v) == 1) begin
         v = 4'($urandom_range((1 << width) - 1));
      end
      return v;
   endfunction

   function automatic scan_item_type scan_of(logic [3:0] c0, logic [3:0] c1, logic [3:0] c2,
                                             logic [3:0] c3, logic tm);
      return {c3, c2, c1, c0, tm};
   endfunction

   function automatic scan_item_type key_scan(int col, int rowbit, bit shift);
      scan_item_type s;
      s.text_mode = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (i < col) begin
            s.cols[i] = 4'($urandom_range(15));
         end else if (i > col) begin
            s.cols[i] = (i == 3) ? (4'(loose_bits(3) << 1) | {3'b000, shift}) : loose_bits(4);
         end else begin
            s.cols[i] = 4'(1 << rowbit);
         end
      end
      if (col == 3) begin
         s.cols[3] = 4'(1 << rowbit) | {3'b000, shift};
      end
      return s;
   endfunction

   function automatic scan_item_type idle_scan();
      scan_item_type s;
      s.text_mode = 1'b1;
      s.cols[0] = loose_bits(4);
      s.cols[1] = loose_bits(4);
      s.cols[2] = loose_bits(4);
      s.cols[3] = 4'(loose_bits(3) << 1) | 4'($urandom_range(1));
      return s;
   endfunction

   function automatic void queue_scan(scan_item_type s);
      pending_scans.push_back(s);
      if (s.text_mode) begin
         queued_items++;
      end
   endfunction

   task automatic tap_key(int col, int rowbit, bit shift, int hold, int gap);
      repeat (hold) queue_scan(key_scan(col, rowbit, shift));
      repeat (gap) queue_scan(idle_scan());
   endtask

   task automatic random_burst(int count);
      int            target;
      int            pick;
      int            col;
      int            rowbit;
      int            cap;
      bit            shift;
      scan_item_type s;
      target = queued_items + count;
      cap = (timeout_ticks + 2 > 20) ? 20 : timeout_ticks + 2;
      while (queued_items < target) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            s.cols = 16'($urandom);
            s.text_mode = 1'($urandom);
            queue_scan(s);
         end else if (pick < 30) begin
            shift = 1'($urandom_range(1));
            if (shift) begin
               col = $urandom_range(3);
               rowbit = (col == 3) ? $urandom_range(1, 3) : $urandom_range(3);
            end else begin
               col = $urandom_range(2);
               rowbit = 0;
            end
            tap_key(col, rowbit, shift, $urandom_range(1, 3), $urandom_range(2));
         end else begin
            col = $urandom_range(3);
            rowbit = $urandom_range(1, 3);
            repeat ($urandom_range(1, 6)) begin
               tap_key(col, rowbit, 1'b0, $urandom_range(1, 3),
                       ($urandom_range(99) < 20) ? $urandom_range(cap) : $urandom_range(3));
            end
         end
      end
   endtask

   task automatic settle();
      while (pending_scans.size() != 0 || awaited_results.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timeout(logic [CHAR_W-1:0] ticks);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      timeout_ticks = ticks;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(entry_result(pending_scans.pop_front()));
         end
         if (!req_valid || !req_stall) begin
            if (pending_scans.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_scan_col0 <= pending_scans[0].cols[0];
               req_scan_col1 <= pending_scans[0].cols[1];
               req_scan_col2 <= pending_scans[0].cols[2];
               req_scan_col3 <= pending_scans[0].cols[3];
               req_text_mode <= pending_scans[0].text_mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 100 && pending_scans.size() > 40) begin
         rsp_stall <= 1'b1;
         hold_left <= 60;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with nothing pending, status", rsp_status, -1);
         end else begin
            want = awaited_results.pop_front();
            results_seen++;
            if (rsp_status !== want.status) begin
               report_mismatch("status", rsp_status, want.status);
            end
            if (rsp_out_char !== want.out_char) begin
               report_mismatch("out_char", rsp_out_char, want.out_char);
            end
            if (rsp_char_written !== want.char_written) begin
               report_mismatch("char_written", rsp_char_written, want.char_written);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_scan(scan_of(4'h8, 4'h0, 4'h0, 4'h0, 1'b0));
      queue_scan(scan_of(4'hF, 4'hF, 4'hF, 4'hF, 1'b1));
      queue_scan(scan_of(4'h1, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h1, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h3, 4'h5, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h0, 4'h8, 4'h0, 4'h1, 1'b1));
      queue_scan(scan_of(4'h0, 4'h0, 4'h0, 4'h1, 1'b1));
      queue_scan(scan_of(4'h8, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h0, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h8, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h0, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h8, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h4, 4'h0, 4'h0, 4'h0, 1'b1));
      queue_scan(scan_of(4'h4, 4'h0, 4'h0, 4'h0, 1'b1));
      repeat (10) queue_scan(scan_of(4'h0, 4'h0, 4'h0, 4'h0, 1'b1));
      settle();

      set_timeout(8'd0);
      queue_scan(scan_of(4'h8, 4'h0, 4'h0, 4'h4, 1'b1));
      queue_scan(scan_of(4'h0, 4'h0, 4'h0, 4'h0, 1'b1));
      random_burst(120);
      settle();

      set_timeout(8'd255);
      tap_key(0, 1, 1'b0, 1, 258);
      random_burst(200);
      settle();

      set_timeout(8'd3);
      random_burst(200);
      settle();

      set_timeout(8'($urandom_range(4, 254)));
      random_burst(200);
      settle();

      set_timeout(8'd1);
      random_burst(150);
      settle();

      idle_pct = 0;
      set_timeout(8'd10);
      random_burst(150);
      settle();

      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
rtl/mtke_pkg.sv
rtl/mtke_decode.sv
rtl/mtke_tap.sv
rtl/multitap_keypad_entry.sv
sim/multitap_keypad_entry_test.sv
